// ===== rtl/ddp_pkg.sv =====
`default_nettype none

package ddp_pkg;

    // Field widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SPEED_W    = 24;
    localparam int WDOG_W     = 16;
    localparam int DUTY_W     = 7;

    // Shared multiplier: 25x17 signed, full product
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WHEELBASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_WHEEL_RADIUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_SCALE       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS    = 2'd3;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] HALF_WHEELBASE_RST   = 16'd6554;
    localparam logic [CFG_DATA_W-1:0] INV_WHEEL_RADIUS_RST = 16'd7314;
    localparam logic [CFG_DATA_W-1:0] DUTY_SCALE_RST       = 16'd20860;
    localparam logic [CFG_DATA_W-1:0] TIMEOUT_TICKS_RST    = 16'd1000;

    // Request opcodes
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_COMMAND = 1'b1;

    // Result kinds
    localparam logic KIND_DRIVE = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;
    localparam logic [WDOG_W-1:0] WDOG_SAT = 16'hFFFF;

    // Multiplier operand select codes
    localparam logic [2:0] MS_TERM  = 3'd0;  // angular * half wheelbase
    localparam logic [2:0] MS_DIFF_L = 3'd1; // (lin - term) * inv radius
    localparam logic [2:0] MS_DIFF_R = 3'd2; // (lin + term) * inv radius
    localparam logic [2:0] MS_MAG_L = 3'd3;  // |left target| * duty scale
    localparam logic [2:0] MS_MAG_R = 3'd4;  // |right target| * duty scale

    typedef struct packed {
        logic               op;
        logic               enable;
        logic signed [15:0] fwd_speed;
        logic signed [15:0] turn_rate;
        logic [31:0]        seq;
    } ddp_in_t;

    typedef struct packed {
        logic              reply_kind;
        logic              accepted;
        logic [31:0]       seq_echo;
        logic              left_forward;
        logic [DUTY_W-1:0] left_duty;
        logic              right_forward;
        logic [DUTY_W-1:0] right_duty;
    } ddp_out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       take;
        logic       mul_en;
        logic [2:0] mul_src;
        logic       wr_left;
        logic       wr_right;
        logic       wr_duty_l;
        logic       wr_duty_r;
        logic       wdog_tick;
        logic       wdog_clear;
        logic       load_out;
    } ddp_ctrl_t;

    // Datapath to controller status
    typedef struct packed {
        logic req_valid;
        logic req_op;
        logic req_enable;
        logic out_free;
    } ddp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/ddp_stream_if.sv =====
`default_nettype none

interface ddp_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/ddp_ctrl.sv =====
`default_nettype none

module ddp_ctrl
    import ddp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire ddp_stat_t stat,
    output ddp_ctrl_t      ctrl
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_TERM    = 4'd1;
    localparam logic [3:0] ST_LEFT    = 4'd2;
    localparam logic [3:0] ST_RIGHT   = 4'd3;
    localparam logic [3:0] ST_RCOMMIT = 4'd4;
    localparam logic [3:0] ST_WDOG    = 4'd5;
    localparam logic [3:0] ST_DUTY_L  = 4'd6;
    localparam logic [3:0] ST_DUTY_R  = 4'd7;
    localparam logic [3:0] ST_DCOMMIT = 4'd8;
    localparam logic [3:0] ST_REPLY   = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencing and datapath commands
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        ctrl.mul_src = MS_TERM;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.take = 1'b1;
                if (stat.req_valid)
                begin
                    if (stat.req_op == OP_TICK)
                    begin
                        state_next = ST_WDOG;
                    end
                    else if (stat.req_enable)
                    begin
                        state_next = ST_TERM;
                    end
                    else
                    begin
                        state_next = ST_REPLY;
                    end
                end
            end
            ST_TERM:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_src = MS_TERM;
                state_next   = ST_LEFT;
            end
            ST_LEFT:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_src = MS_DIFF_L;
                state_next   = ST_RIGHT;
            end
            ST_RIGHT:
            begin
                ctrl.wr_left = 1'b1;
                ctrl.mul_en  = 1'b1;
                ctrl.mul_src = MS_DIFF_R;
                state_next   = ST_RCOMMIT;
            end
            ST_RCOMMIT:
            begin
                ctrl.wr_right   = 1'b1;
                ctrl.wdog_clear = 1'b1;
                state_next      = ST_REPLY;
            end
            ST_WDOG:
            begin
                ctrl.wdog_tick = 1'b1;
                state_next     = ST_DUTY_L;
            end
            ST_DUTY_L:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_src = MS_MAG_L;
                state_next   = ST_DUTY_R;
            end
            ST_DUTY_R:
            begin
                ctrl.wr_duty_l = 1'b1;
                ctrl.mul_en    = 1'b1;
                ctrl.mul_src   = MS_MAG_R;
                state_next     = ST_DCOMMIT;
            end
            ST_DCOMMIT:
            begin
                ctrl.wr_duty_r = 1'b1;
                state_next     = ST_REPLY;
            end
            ST_REPLY:
            begin
                // wait for the output register to free up
                if (stat.out_free)
                begin
                    ctrl.load_out = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/ddp_datapath.sv =====
`default_nettype none

module ddp_datapath
    import ddp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    ddp_stream_if.sink                 req,
    ddp_stream_if.source               rsp,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire ddp_ctrl_t             ctrl,
    output ddp_stat_t                  stat
);

    // Saturate a product shifted right by 8 to the signed speed range
    function automatic logic [SPEED_W-1:0] sat_speed(input logic [PROD_W-1:0] p);
        logic [PROD_W-9:0] s;
        logic [SPEED_W-1:0] r;
        s = p[PROD_W-1:8];
        if ((&s[PROD_W-9:SPEED_W-1]) || !(|s[PROD_W-9:SPEED_W-1]))
        begin
            r = s[SPEED_W-1:0];
        end
        else if (s[PROD_W-9])
        begin
            r = {1'b1, {(SPEED_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(SPEED_W-1){1'b1}}};
        end
        return r;
    endfunction

    // Duty = min(100, product >> 28)
    function automatic logic [DUTY_W-1:0] clamp_duty(input logic [PROD_W-1:0] p);
        logic [PROD_W-29:0] q;
        logic [DUTY_W-1:0]  r;
        q = p[PROD_W-1:28];
        if (q > {{(PROD_W-28-DUTY_W){1'b0}}, DUTY_MAX})
        begin
            r = DUTY_MAX;
        end
        else
        begin
            r = q[DUTY_W-1:0];
        end
        return r;
    endfunction

    // Configuration registers
    logic [CFG_DATA_W-1:0] hwb_reg;
    logic [CFG_DATA_W-1:0] inv_reg;
    logic [CFG_DATA_W-1:0] dscale_reg;
    logic [CFG_DATA_W-1:0] tmo_reg;

    // Control state
    logic [SPEED_W-1:0] left_target_reg;
    logic [SPEED_W-1:0] right_target_reg;
    logic [WDOG_W-1:0]  wdog_reg;
    logic               out_valid_reg;

    // Payload registers
    logic               op_reg;
    logic               en_reg;
    logic signed [15:0] lin_reg;
    logic signed [15:0] ang_reg;
    logic [31:0]        seq_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic signed [17:0] diff_r_reg;
    logic [DUTY_W-1:0]  duty_l_reg;
    logic [DUTY_W-1:0]  duty_r_reg;
    ddp_out_t           out_reg;
    ddp_out_t           out_next;

    logic                      accept;
    logic                      timed_out;
    logic signed [16:0]        term;
    logic signed [17:0]        diff_l;
    logic signed [17:0]        diff_r;
    logic [SPEED_W-1:0]        mag_l;
    logic [SPEED_W-1:0]        mag_r;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;

    assign accept = req.valid && ctrl.take;

    assign req.ready     = ctrl.take;
    assign rsp.valid     = out_valid_reg;
    assign rsp.payload   = out_reg;

    assign stat.req_valid  = req.valid;
    assign stat.req_op     = req.payload.op;
    assign stat.req_enable = req.payload.enable;
    assign stat.out_free   = !out_valid_reg || rsp.ready;

    // Wheel speed differences from the term product
    assign term   = prod_reg[32:16];
    assign diff_l = {{2{lin_reg[15]}}, lin_reg} - {term[16], term};
    assign diff_r = {{2{lin_reg[15]}}, lin_reg} + {term[16], term};

    // Target magnitudes; the most negative value maps to 2^23
    assign mag_l = left_target_reg[SPEED_W-1]  ? (~left_target_reg + 1'b1)  : left_target_reg;
    assign mag_r = right_target_reg[SPEED_W-1] ? (~right_target_reg + 1'b1) : right_target_reg;

    // Shared multiplier operand select
    always_comb
    begin
        case (ctrl.mul_src)
            MS_TERM:
            begin
                mul_a = {{(MUL_A_W-16){ang_reg[15]}}, ang_reg};
                mul_b = {1'b0, hwb_reg};
            end
            MS_DIFF_L:
            begin
                mul_a = {{(MUL_A_W-18){diff_l[17]}}, diff_l};
                mul_b = {1'b0, inv_reg};
            end
            MS_DIFF_R:
            begin
                mul_a = {{(MUL_A_W-18){diff_r_reg[17]}}, diff_r_reg};
                mul_b = {1'b0, inv_reg};
            end
            MS_MAG_L:
            begin
                mul_a = {1'b0, mag_l};
                mul_b = {1'b0, dscale_reg};
            end
            MS_MAG_R:
            begin
                mul_a = {1'b0, mag_r};
                mul_b = {1'b0, dscale_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign timed_out = !en_reg || (wdog_reg >= tmo_reg);

    // Result assembly
    always_comb
    begin
        out_next = '0;
        if (op_reg == OP_COMMAND)
        begin
            out_next.reply_kind = KIND_REPLY;
            out_next.accepted   = en_reg;
            out_next.seq_echo   = seq_reg;
        end
        else
        begin
            out_next.reply_kind    = KIND_DRIVE;
            out_next.left_forward  = ~left_target_reg[SPEED_W-1];
            out_next.left_duty     = duty_l_reg;
            out_next.right_forward = ~right_target_reg[SPEED_W-1];
            out_next.right_duty    = duty_r_reg;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hwb_reg    <= HALF_WHEELBASE_RST;
            inv_reg    <= INV_WHEEL_RADIUS_RST;
            dscale_reg <= DUTY_SCALE_RST;
            tmo_reg    <= TIMEOUT_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HALF_WHEELBASE:   hwb_reg    <= cfg_data;
                CFG_INV_WHEEL_RADIUS: inv_reg    <= cfg_data;
                CFG_DUTY_SCALE:       dscale_reg <= cfg_data;
                CFG_TIMEOUT_TICKS:    tmo_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Wheel targets and watchdog
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_target_reg  <= '0;
            right_target_reg <= '0;
            wdog_reg         <= WDOG_SAT;
        end
        else
        begin
            if (ctrl.wdog_tick)
            begin
                if (timed_out)
                begin
                    left_target_reg  <= '0;
                    right_target_reg <= '0;
                end
                if (wdog_reg != WDOG_SAT)
                begin
                    wdog_reg <= wdog_reg + 1'b1;
                end
            end
            if (ctrl.wr_left)
            begin
                left_target_reg <= sat_speed(prod_reg);
            end
            if (ctrl.wr_right)
            begin
                right_target_reg <= sat_speed(prod_reg);
            end
            if (ctrl.wdog_clear)
            begin
                wdog_reg <= '0;
            end
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Request capture, product and intermediate results
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= req.payload.op;
            en_reg  <= req.payload.enable;
            lin_reg <= req.payload.fwd_speed;
            ang_reg <= req.payload.turn_rate;
            seq_reg <= req.payload.seq;
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= mul_p;
        end
        if (ctrl.mul_src == MS_DIFF_L)
        begin
            diff_r_reg <= diff_r;
        end
        if (ctrl.wr_duty_l)
        begin
            duty_l_reg <= clamp_duty(prod_reg);
        end
        if (ctrl.wr_duty_r)
        begin
            duty_r_reg <= clamp_duty(prod_reg);
        end
        if (ctrl.load_out)
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/diff_drive_command_to_pwm.sv =====
// Differential drive command to motor PWM.
// Request channel (req): op = 1 carries a velocity command (linear and
// angular velocity, sequence number), op = 0 is a control tick. Every
// request gives exactly one result on the result channel (rsp): a command
// reply with accepted and seq_echo, or a tick result with direction and a
// 0..100 duty for each motor.
// Requests are taken one at a time on a single shared 25x17 multiplier.
// An enabled command runs three multiplies (turn term, left, right) and a
// tick runs two (left and right duty); a rejected command (enable low)
// runs none. The result is registered from the reply state, which waits
// until the output register is free, and only then is a new request taken.
// The result sits in an output register; if the receiver stalls, the block
// finishes the next request and holds it until the register is taken.
// Reset restores the register defaults, zeroes both wheel targets and sets
// the watchdog to timed out, so ticks give zero duty until a command lands.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once;
// the user makes them while the block is idle; the block does not check.
`default_nettype none

module diff_drive_command_to_pwm
    import ddp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    ddp_stream_if.sink                 req,
    ddp_stream_if.source               rsp,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    ddp_ctrl_t ctrl;
    ddp_stat_t stat;

    // Sequencer
    ddp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    // Arithmetic, state and channel registers
    ddp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctrl      (ctrl),
        .stat      (stat)
    );

endmodule

`default_nettype wire

// ===== test/diff_drive_command_to_pwm_test.sv =====
`timescale 1ns / 1ps

module diff_drive_command_to_pwm_test
    import ddp_pkg::*;
();

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 3;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 68;
    localparam int STALL_CYCLES  = 80;
    localparam int STALL_ITEMS   = 12;

    // Fixed-point scaling of the kinematics and the duty
    localparam int TERM_SHIFT  = 16;
    localparam int WHEEL_SHIFT = 8;
    localparam int DUTY_SHIFT  = 28;
    localparam longint SPEED_HI = longint'(2 ** (SPEED_W - 1)) - 1;
    localparam longint SPEED_LO = -longint'(2 ** (SPEED_W - 1));

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ddp_stream_if #(.payload_t(ddp_in_t)) req_if ();
    ddp_stream_if #(.payload_t(ddp_out_t)) rsp_if ();

    diff_drive_command_to_pwm DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_if),
        .rsp(rsp_if),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Predictor copy of the registers and the drive state
    logic [CFG_DATA_W-1:0] half_wb = HALF_WHEELBASE_RST;
    logic [CFG_DATA_W-1:0] inv_rad = INV_WHEEL_RADIUS_RST;
    logic [CFG_DATA_W-1:0] duty_k = DUTY_SCALE_RST;
    logic [CFG_DATA_W-1:0] timeout_k = TIMEOUT_TICKS_RST;
    logic signed [SPEED_W-1:0] left_tgt = '0;
    logic signed [SPEED_W-1:0] right_tgt = '0;
    logic [WDOG_W-1:0] wdog = WDOG_SAT;

    ddp_out_t drive_due[$];

    int errors = 0;
    int n_accepted = 0;
    int n_rejected = 0;
    int n_ticks = 0;
    int n_zeroed = 0;
    int n_saturated = 0;
    int n_clamped = 0;
    int n_results = 0;
    int cycles = 0;

    // Idling controls
    bit send_steady = 1'b0;
    bit take_steady = 1'b0;
    int hold_ask = 0;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Run limit
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("diff_drive_command_to_pwm verification failed");
        $finish;
    end

    function automatic logic signed [SPEED_W-1:0] clamp_speed(longint v);
        if (v > SPEED_HI)
        begin
            n_saturated++;
            return SPEED_HI[SPEED_W-1:0];
        end
        if (v < SPEED_LO)
        begin
            n_saturated++;
            return SPEED_LO[SPEED_W-1:0];
        end
        return v[SPEED_W-1:0];
    endfunction

    function automatic logic [DUTY_W-1:0] duty_pct(logic signed [SPEED_W-1:0] t);
        longint mag;
        longint d;
        mag = (t < 0) ? -longint'(t) : longint'(t);
        d = (mag * longint'(duty_k)) >>> DUTY_SHIFT;
        if (d > longint'(DUTY_MAX))
        begin
            n_clamped++;
            return DUTY_MAX;
        end
        return d[DUTY_W-1:0];
    endfunction

    // Expected result of one request; advances the drive state
    function automatic ddp_out_t predict_drive(ddp_in_t r);
        ddp_out_t o;
        longint lin;
        longint ang;
        longint term;
        o = '0;
        if (r.op == OP_COMMAND)
        begin
            o.reply_kind = KIND_REPLY;
            o.seq_echo = r.seq;
            if (r.enable)
            begin
                lin = r.fwd_speed;
                ang = r.turn_rate;
                term = (ang * longint'(half_wb)) >>> TERM_SHIFT;
                left_tgt = clamp_speed(((lin - term) * longint'(inv_rad)) >>> WHEEL_SHIFT);
                right_tgt = clamp_speed(((lin + term) * longint'(inv_rad)) >>> WHEEL_SHIFT);
                wdog = '0;
                o.accepted = 1'b1;
                n_accepted++;
            end
            else
                n_rejected++;
        end
        else
        begin
            n_ticks++;
            // timeout check uses the count before this tick
            if (!r.enable || wdog >= timeout_k)
            begin
                left_tgt = '0;
                right_tgt = '0;
                n_zeroed++;
            end
            if (wdog != WDOG_SAT)
                wdog++;
            o.reply_kind = KIND_DRIVE;
            o.left_forward = (left_tgt >= 0);
            o.left_duty = duty_pct(left_tgt);
            o.right_forward = (right_tgt >= 0);
            o.right_duty = duty_pct(right_tgt);
        end
        return o;
    endfunction

    // Gap lengths: mostly short, a few long
    function automatic int pause_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [15:0] rand_vel();
        int pick;
        int v;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 16'sh7FFF;
        if (pick == 1)
            return 16'sh8000;
        if (pick < 6)
        begin
            v = int'($urandom_range(0, 4000)) - 2000;
            return v[15:0];
        end
        v = $urandom;
        return v[15:0];
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        logic [CFG_DATA_W-1:0] v;
        v = CFG_DATA_W'($urandom);
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            default: return v;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_timeout();
        logic [CFG_DATA_W-1:0] v;
        v = CFG_DATA_W'($urandom);
        case ($urandom_range(0, 6))
            0: return '0;
            1: return CFG_DATA_W'(1);
            2: return '1;
            3, 4: return CFG_DATA_W'($urandom_range(2, 12));
            default: return v;
        endcase
    endfunction

    // Result receiver with random stalls and a long hold on request
    initial
    begin
        int idle_left;
        idle_left = 0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_ask > 0)
            begin
                idle_left = hold_ask;
                hold_ask = 0;
            end
            else if (idle_left == 0 && !take_steady && $urandom_range(0, 99) < 20)
                idle_left = pause_len();
            if (idle_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                idle_left--;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    task automatic compare_field(string name, longint want, longint got);
        if (want != got)
        begin
            errors++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        ddp_out_t got;
        ddp_out_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got = rsp_if.payload;
            n_results++;
            if (drive_due.size() == 0)
            begin
                errors++;
                $error("result with nothing pending: %p", got);
            end
            else
            begin
                want = drive_due.pop_front();
                compare_field("reply_kind", longint'(want.reply_kind),
                              longint'(got.reply_kind));
                compare_field("accepted", longint'(want.accepted),
                              longint'(got.accepted));
                compare_field("seq_echo", longint'(want.seq_echo),
                              longint'(got.seq_echo));
                compare_field("left_forward", longint'(want.left_forward),
                              longint'(got.left_forward));
                compare_field("left_duty", longint'(want.left_duty),
                              longint'(got.left_duty));
                compare_field("right_forward", longint'(want.right_forward),
                              longint'(got.right_forward));
                compare_field("right_duty", longint'(want.right_duty),
                              longint'(got.right_duty));
            end
        end
    end

    // Offer one request and wait for it to be taken
    task automatic send_request(ddp_in_t item);
        int gap;
        gap = (send_steady || $urandom_range(0, 1)) ? 0 : pause_len();
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.payload <= item;
        do
            @(posedge clk);
        while (!req_if.ready);
        drive_due.push_back(predict_drive(item));
    endtask

    task automatic issue(logic op, logic en, logic signed [15:0] lin,
                         logic signed [15:0] ang);
        ddp_in_t item;
        item.op = op;
        item.enable = en;
        item.fwd_speed = lin;
        item.turn_rate = ang;
        item.seq = $urandom;
        send_request(item);
    endtask

    // Wait until every pending result has come back
    task automatic settle();
        req_if.valid <= 1'b0;
        while (drive_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // Write all four registers; only called while idle
    task automatic load_settings(logic [CFG_DATA_W-1:0] hw, logic [CFG_DATA_W-1:0] ir,
                                 logic [CFG_DATA_W-1:0] ds, logic [CFG_DATA_W-1:0] to);
        put_reg(CFG_HALF_WHEELBASE, hw);
        put_reg(CFG_INV_WHEEL_RADIUS, ir);
        put_reg(CFG_DUTY_SCALE, ds);
        put_reg(CFG_TIMEOUT_TICKS, to);
        cfg_we <= 1'b0;
        half_wb = hw;
        inv_rad = ir;
        duty_k = ds;
        timeout_k = to;
    endtask

    // Watchdog starts timed out, so ticks drive nothing until a command lands
    task automatic test_after_reset();
        issue(OP_TICK, 1'b1, 16'sh7FFF, 16'sh8000);
        issue(OP_COMMAND, 1'b0, 16'sd1000, 16'sd500);
        issue(OP_TICK, 1'b1, 16'sd0, 16'sd0);
        settle();
    endtask

    // Ordinary commands with the reset gains, then enable dropped on a tick
    task automatic test_default_drive();
        issue(OP_COMMAND, 1'b1, 16'sd4096, 16'sd0);
        issue(OP_TICK, 1'b1, 16'sd0, 16'sd0);
        issue(OP_COMMAND, 1'b1, -16'sd4096, 16'sd2048);
        issue(OP_TICK, 1'b1, 16'sd0, 16'sd0);
        issue(OP_COMMAND, 1'b1, 16'sd0, 16'sh7FFF);
        issue(OP_TICK, 1'b1, 16'sd0, 16'sd0);
        issue(OP_TICK, 1'b0, 16'sd0, 16'sd0);
        issue(OP_TICK, 1'b1, 16'sd0, 16'sd0);
        settle();
    endtask

    // Largest and zero gains: saturated targets, clamped and zero duty
    task automatic test_gain_extremes();
        ddp_in_t item;
        load_settings('1, '1, '1, TIMEOUT_TICKS_RST);
        issue(OP_COMMAND, 1'b1, 16'sh7FFF, 16'sh8000);
        issue(OP_TICK, 1'b1, 16'sd0, 16'sd0);
        issue(OP_COMMAND, 1'b1, 16'sh8000, 16'sh7FFF);
        issue(OP_TICK, 1'b1, 16'sd0, 16'sd0);
        settle();
        load_settings('0, '0, '0, CFG_DATA_W'(1));
        issue(OP_COMMAND, 1'b1, 16'sh7FFF, 16'sh7FFF);
        issue(OP_TICK, 1'b1, 16'sd0, 16'sd0);
        // rejected command with an all-ones sequence number
        item = '{op: OP_COMMAND, enable: 1'b0, fwd_speed: 16'sd1, turn_rate: -16'sd1,
                 seq: '1};
        send_request(item);
        settle();
    endtask

    // Watchdog expiry, zero timeout and the largest timeout
    task automatic test_watchdog();
        load_settings(HALF_WHEELBASE_RST, INV_WHEEL_RADIUS_RST, DUTY_SCALE_RST,
                      CFG_DATA_W'(3));
        issue(OP_COMMAND, 1'b1, 16'sd4096, 16'sd1024);
        repeat (4) issue(OP_TICK, 1'b1, 16'sd0, 16'sd0);
        settle();
        load_settings(HALF_WHEELBASE_RST, INV_WHEEL_RADIUS_RST, DUTY_SCALE_RST, '0);
        issue(OP_COMMAND, 1'b1, 16'sd4096, 16'sd0);
        issue(OP_TICK, 1'b1, 16'sd0, 16'sd0);
        settle();
        load_settings(HALF_WHEELBASE_RST, INV_WHEEL_RADIUS_RST, DUTY_SCALE_RST, '1);
        issue(OP_COMMAND, 1'b1, -16'sd8192, 16'sd4096);
        repeat (2) issue(OP_TICK, 1'b1, 16'sd0, 16'sd0);
        settle();
    endtask

    // Receiver holds off while requests keep coming, so the block backs up
    task automatic test_output_stall();
        load_settings(HALF_WHEELBASE_RST, INV_WHEEL_RADIUS_RST, DUTY_SCALE_RST,
                      TIMEOUT_TICKS_RST);
        send_steady = 1'b1;
        hold_ask = STALL_CYCLES;
        for (int i = 0; i < STALL_ITEMS; i++)
            issue((i % 2 == 0) ? OP_COMMAND : OP_TICK, 1'b1, rand_vel(), rand_vel());
        send_steady = 1'b0;
        settle();
    endtask

    // Command followed by a burst of ticks, with some noise, over several settings
    task automatic test_random_traffic();
        int count;
        int burst;
        logic [15:0] junk_a;
        logic [15:0] junk_b;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
                load_settings(HALF_WHEELBASE_RST, INV_WHEEL_RADIUS_RST, DUTY_SCALE_RST,
                              TIMEOUT_TICKS_RST);
            else
                load_settings(pick_gain(), pick_gain(), pick_gain(), pick_timeout());
            send_steady = (phase == 3);
            take_steady = (phase == 3);
            count = 0;
            while (count < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    issue(OP_COMMAND, $urandom_range(0, 9) != 0, rand_vel(), rand_vel());
                    burst = $urandom_range(0, 5);
                    for (int k = 0; k < burst; k++)
                    begin
                        junk_a = 16'($urandom);
                        junk_b = 16'($urandom);
                        issue(OP_TICK, $urandom_range(0, 14) != 0, junk_a, junk_b);
                    end
                    count += 1 + burst;
                end
                else
                begin
                    issue(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          rand_vel(), rand_vel());
                    count++;
                end
            end
            send_steady = 1'b0;
            take_steady = 1'b0;
            settle();
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        req_if.valid <= 1'b0;
        req_if.payload <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_default_drive();
        test_gain_extremes();
        test_watchdog();
        test_output_stall();
        test_random_traffic();

        if (drive_due.size() != 0)
        begin
            errors++;
            $error("%0d results never arrived", drive_due.size());
        end
        $display("Covered %0d accepted and %0d rejected commands, %0d ticks (%0d zeroing).",
                 n_accepted, n_rejected, n_ticks, n_zeroed);
        $display("%0d saturated wheel speeds, %0d clamped duties, %0d results checked.",
                 n_saturated, n_clamped, n_results);
        if (errors == 0)
            $display("diff_drive_command_to_pwm verification clean");
        else
            $display("diff_drive_command_to_pwm verification failed");
        $finish;
    end

endmodule
